// ===== rtl/dbd_pkg.sv =====
// Shared widths, constants, microcode types and the month table for the date difference block.
`timescale 1ns / 1ps

package dbd_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int COUNT_W  = 22;
	localparam int DAYNUM_W = 23;
	localparam int MULB_W   = 13;
	localparam int PROD_W   = YEAR_W + MULB_W;
	localparam int Q100_W   = 8;
	localparam int Q400_W   = 6;
	localparam int CUM_W    = 9;
	localparam int STEP_W   = 3;

	// floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2**YEAR_W
	localparam logic [MULB_W-1:0] RECIP_100   = 13'd5243;
	localparam int                RECIP_SHIFT = 19;
	localparam logic [MULB_W-1:0] YEAR_DAYS   = 13'd365;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_P_RECIP,
		MUL_Q_RECIP,
		MUL_P_YEAR
	} mul_op_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_INIT,
		ACC_ADD_P4,
		ACC_SUB_Q100,
		ACC_ADD_Q400,
		ACC_ADD_PROD
	} acc_op_t;

	typedef enum logic {
		BR_NONE,
		BR_FIRST
	} br_op_t;

	typedef struct packed {
		mul_op_t             mul_op;
		acc_op_t             acc_op;
		logic                q100_ld;
		logic                q400_ld;
		logic                leap_ld;
		br_op_t              br_op;
		logic                emit;
		logic [STEP_W-1:0]   target;
	} ctrl_t;

	// days in the months before month m of a common year
	function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
		logic [CUM_W-1:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/dbd_in_if.sv =====
// Input channel: a start date and an end date with valid/ready handshake.
`timescale 1ns / 1ps

interface dbd_in_if import dbd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [YEAR_W-1:0]  start_year;
	logic [MONTH_W-1:0] start_month;
	logic [DAY_W-1:0]   start_day;
	logic [YEAR_W-1:0]  end_year;
	logic [MONTH_W-1:0] end_month;
	logic [DAY_W-1:0]   end_day;

	modport source (
		output valid, start_year, start_month, start_day, end_year, end_month, end_day,
		input  ready
	);

	modport sink (
		input  valid, start_year, start_month, start_day, end_year, end_month, end_day,
		output ready
	);
endinterface

// ===== rtl/dbd_out_if.sv =====
// Output channel: inclusive day count and order error with valid/ready handshake.
`timescale 1ns / 1ps

interface dbd_out_if import dbd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] day_count;
	logic               order_error;

	modport source (
		output valid, day_count, order_error,
		input  ready
	);

	modport sink (
		input  valid, day_count, order_error,
		output ready
	);
endinterface

// ===== rtl/dbd_seq.sv =====
// Microcode sequencer: step counter, control store and branch logic.
`timescale 1ns / 1ps

module dbd_seq import dbd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  cond,
	input  logic  stall,
	output logic  busy,
	output ctrl_t ctrl
);

	localparam ctrl_t CTRL_IDLE = '{
		mul_op:  MUL_NONE,
		acc_op:  ACC_HOLD,
		q100_ld: 1'b0,
		q400_ld: 1'b0,
		leap_ld: 1'b0,
		br_op:   BR_NONE,
		emit:    1'b0,
		target:  '0
	};

	localparam logic [STEP_W-1:0] STEP_LOAD = 3'd0;

	// one date is converted by steps 0..6; step 6 loops back once for the end date
	function automatic ctrl_t rom(input logic [STEP_W-1:0] s);
		ctrl_t c;
		c = CTRL_IDLE;
		unique case (s)
			3'd0: c.acc_op = ACC_INIT;
			3'd1: begin
				c.mul_op = MUL_P_RECIP;
				c.acc_op = ACC_ADD_P4;
			end
			3'd2: begin
				c.q100_ld = 1'b1;
				c.mul_op  = MUL_Q_RECIP;
			end
			3'd3: begin
				c.q400_ld = 1'b1;
				c.acc_op  = ACC_SUB_Q100;
				c.mul_op  = MUL_P_YEAR;
			end
			3'd4: begin
				c.acc_op  = ACC_ADD_Q400;
				c.leap_ld = 1'b1;
			end
			3'd5: c.acc_op = ACC_ADD_PROD;
			3'd6: begin
				c.br_op  = BR_FIRST;
				c.target = STEP_LOAD;
			end
			3'd7: c.emit = 1'b1;
		endcase
		return c;
	endfunction

	logic              busy_q;
	logic [STEP_W-1:0] step_q;

	assign busy = busy_q;
	assign ctrl = busy_q ? rom(step_q) : CTRL_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_LOAD;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_LOAD;
		end else if (busy_q) begin
			if (ctrl.emit) begin
				// hold on the last step until the output word can be written
				if (!stall) begin
					busy_q <= 1'b0;
					step_q <= STEP_LOAD;
				end
			end else if (ctrl.br_op == BR_FIRST && cond) begin
				step_q <= ctrl.target;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	a_emit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && ctrl.emit && !stall && !start |=> !busy_q)
		else $error("sequencer stayed busy after emitting");

endmodule

// ===== rtl/gregorian_days_between_dates_top.sv =====
// Inclusive Gregorian day count between two dates, microcoded datapath.
// The control program runs 7 steps per date plus one emit step, one step per cycle
// while the emit step is not held by a stalled output, on a single shared multiplier.
// No new item is accepted while the sequencer is busy.
// A new item is taken while the previous result still waits in the output register.
// Reset (arst_n low, asynchronous) clears the sequencer and the output valid flag.
`timescale 1ns / 1ps

module gregorian_days_between_dates_top import dbd_pkg::*; #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic       clk,
	input  logic       arst_n,
	dbd_in_if.sink     req,
	dbd_out_if.source  rsp
);

	ctrl_t ctrl;
	logic  busy;
	logic  accept;
	logic  stall;
	logic  do_emit;

	logic [YEAR_W-1:0]   sy_q, ey_q;
	logic [MONTH_W-1:0]  sm_q, em_q;
	logic [DAY_W-1:0]    sd_q, ed_q;
	logic                sel_q;

	logic [YEAR_W-1:0]   p_q;
	logic                m3_q;
	logic [DAYNUM_W-1:0] acc_q;
	logic [DAYNUM_W-1:0] a_q;
	logic [PROD_W-1:0]   mul_q;
	logic [Q100_W-1:0]   q100_q;
	logic [Q400_W-1:0]   q400_q;
	logic                leap_q;

	logic                out_valid_q;
	logic [COUNT_W-1:0]  day_count_q;
	logic                order_error_q;

	logic [YEAR_W-1:0]   cur_y, y_clamp;
	logic [MONTH_W-1:0]  cur_m, m_clamp;
	logic [DAY_W-1:0]    cur_d;
	logic [YEAR_W-1:0]   mul_a;
	logic [MULB_W-1:0]   mul_b;
	logic [YEAR_W-1:0]   r100;
	logic [YEAR_W-3:0]   r400;
	logic                leap;
	logic [DAYNUM_W:0]   diff;
	logic [DAYNUM_W:0]   span;

	assign accept    = req.valid && req.ready;
	assign req.ready = !busy;
	assign stall     = out_valid_q && !rsp.ready;
	assign do_emit   = ctrl.emit && !stall;

	dbd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.cond   (!sel_q),
		.stall  (stall),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	// select and clamp the date being converted
	always_comb begin
		cur_y = sel_q ? ey_q : sy_q;
		cur_m = sel_q ? em_q : sm_q;
		cur_d = sel_q ? ed_q : sd_q;
		if (cur_y == '0)
			y_clamp = YEAR_W'(1);
		else if (32'(cur_y) > 32'(MAX_YEAR))
			y_clamp = YEAR_W'(MAX_YEAR);
		else
			y_clamp = cur_y;
		if (cur_m < MONTH_JAN)
			m_clamp = MONTH_JAN;
		else if (cur_m > MONTH_DEC)
			m_clamp = MONTH_DEC;
		else
			m_clamp = cur_m;
	end

	always_comb begin
		case (ctrl.mul_op)
			MUL_P_RECIP: begin
				mul_a = p_q;
				mul_b = RECIP_100;
			end
			MUL_Q_RECIP: begin
				mul_a = {2'b00, p_q[YEAR_W-1:2]};
				mul_b = RECIP_100;
			end
			MUL_P_YEAR: begin
				mul_a = p_q;
				mul_b = YEAR_DAYS;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// year y = p + 1 ends a century when p mod 100 is 99, a 400-year cycle when
	// (p / 4) mod 100 is 99 and p mod 4 is 3
	always_comb begin
		r100 = p_q - YEAR_W'(q100_q) * YEAR_W'(100);
		r400 = p_q[YEAR_W-1:2] - (YEAR_W-2)'(q400_q) * (YEAR_W-2)'(100);
		leap = (p_q[1:0] == 2'b11) &&
			((r100 != YEAR_W'(99)) || (r400 == (YEAR_W-2)'(99)));
	end

	always_comb begin
		diff = {1'b0, acc_q} - {1'b0, a_q};
		span = diff + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sy_q <= req.start_year;
			sm_q <= req.start_month;
			sd_q <= req.start_day;
			ey_q <= req.end_year;
			em_q <= req.end_month;
			ed_q <= req.end_day;
		end
		if (ctrl.acc_op == ACC_INIT) begin
			p_q  <= y_clamp - 1'b1;
			m3_q <= m_clamp > MONTH_FEB;
		end
		if (ctrl.mul_op != MUL_NONE)
			mul_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		if (ctrl.q100_ld)
			q100_q <= mul_q[RECIP_SHIFT +: Q100_W];
		if (ctrl.q400_ld)
			q400_q <= mul_q[RECIP_SHIFT +: Q400_W];
		if (ctrl.leap_ld)
			leap_q <= leap;
		case (ctrl.acc_op)
			ACC_INIT:     acc_q <= DAYNUM_W'(cur_d) + DAYNUM_W'(cum_days(m_clamp));
			ACC_ADD_P4:   acc_q <= acc_q + DAYNUM_W'(p_q[YEAR_W-1:2]);
			ACC_SUB_Q100: acc_q <= acc_q - DAYNUM_W'(q100_q);
			ACC_ADD_Q400: acc_q <= acc_q + DAYNUM_W'(q400_q);
			ACC_ADD_PROD: acc_q <= acc_q + mul_q[DAYNUM_W-1:0] + DAYNUM_W'(leap_q & m3_q);
			default:      acc_q <= acc_q;
		endcase
		if (ctrl.br_op == BR_FIRST && !sel_q)
			a_q <= acc_q;
		if (do_emit) begin
			if (diff[DAYNUM_W]) begin
				day_count_q   <= '0;
				order_error_q <= 1'b1;
			end else begin
				day_count_q   <= (span > (DAYNUM_W+1)'(COUNT_MAX)) ? COUNT_MAX
					: span[COUNT_W-1:0];
				order_error_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// drop back to the start date when an item is accepted or once the word is written
			if (accept || do_emit)
				sel_q <= 1'b0;
			else if (ctrl.br_op == BR_FIRST && !sel_q)
				sel_q <= 1'b1;
			if (do_emit)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.day_count   = day_count_q;
	assign rsp.order_error = order_error_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.order_error |-> rsp.day_count == '0)
		else $error("order error with nonzero count");

	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.order_error |-> rsp.day_count != '0)
		else $error("zero count without order error");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("input accepted while busy");

	a_sel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> busy)
		else $error("end date selected while idle");

endmodule
